FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros for the terminal engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset
`define TTE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define TTE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Types and constants of the text terminal output engine.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // request types
  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_COLOR = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CELL   = 2'd0;
  localparam logic [1:0] KIND_CURSOR = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // escape phases
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_CSI  = 2'd2;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_FINLO = 8'h40;
  localparam logic [7:0] CH_FINHI = 8'h7E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [3:0] FG_RESET = 4'hF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [7:0] new_fg;
    logic [7:0] new_bg;
    logic [7:0] new_attr;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] out_row;
    logic [6:0] out_col;
    logic [7:0] out_char;
    logic [3:0] out_fg;
    logic [3:0] out_bg;
    logic [7:0] out_attr;
    logic       last;
  } out_t;

  // stored cell: char, fg, bg, attr
  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [7:0] attr;
  } cell_t;

endpackage

FILE: src/text_terminal_output_engine_unit.sv
// ----------------------------------------------------------------------------
// text_terminal_output_engine_unit
// Cursor, escape skipping and cell store of one virtual text screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req and raise start; the word is taken at an edge where
//   start is high and busy is low. Output: each result word sits on res for
//   one cycle with strobe high; res.last marks the final word of a request.
//   The receiver cannot stall; results are never held.
// Sequencing:
//   CR, LF (no scroll), set-colors and escape bytes: done in the idle state.
//   Printable byte: cell write, then cursor. Backspace: erase, then cursor.
//   Cell read: on screen, a registered memory read, then the read word; off screen, in the idle state.
//   Tab: a cell write and then a cursor word for each space, up to 8 spaces.
//   A scroll, on a wrap or on LF, emits a scroll notice and then clears the
//   new bottom row before the cursor word.
//   These steps follow from the single write port of the cell memory.
// Scrolling rotates a top-row pointer; rows are never copied.
// Reset: a clearing pass writes the reset cell into every on-screen cell;
//   busy stays high during it.
// ----------------------------------------------------------------------------
module text_terminal_output_engine_unit #(
  parameter int COLUMNS = tte_pkg::DEF_COLUMNS,
  parameter int ROWS    = tte_pkg::DEF_ROWS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tte_pkg::in_t  req,
  output logic          strobe,
  output tte_pkg::out_t res
);
  `include "assert_macros.svh"

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS << CW;

  localparam logic [3:0] S_RCLR = 4'd0;  // reset clearing pass
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_PUT  = 4'd2;  // write one printable cell
  localparam logic [3:0] S_CUR  = 4'd3;  // emit cursor
  localparam logic [3:0] S_SCRL = 4'd4;  // emit scroll notice
  localparam logic [3:0] S_CLRR = 4'd5;  // clear new bottom row
  localparam logic [3:0] S_RD   = 4'd6;  // read data back

  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
  localparam logic [7:0] COL_END  = 8'(COLUMNS);

  tte_pkg::cell_t mem [DEPTH];
  tte_pkg::cell_t rd_q;

  logic [3:0]   state;
  logic [1:0]   phase;
  logic [4:0]   cur_row;
  logic [6:0]   cur_col;
  logic [3:0]   cur_fg, cur_bg;
  logic [7:0]   cur_attr;
  logic [RW-1:0] top;
  logic [7:0]   ch;
  logic         tab;
  logic         more;
  logic [7:0]   stop;
  logic [RW-1:0] clr_r;
  logic [CW-1:0] clr_c;
  logic [4:0]   rd_row;
  logic [6:0]   rd_col;

  logic         we;
  logic [AW-1:0] waddr, raddr;
  tte_pkg::cell_t wdata;
  logic [6:0]   bs_col;
  logic [7:0]   col_inc;
  logic         rd_in;

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] r, input logic [RW-1:0] t);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, t};
    if (s >= (RW+1)'(ROWS)) s = s - (RW+1)'(ROWS);
    return s[RW-1:0];
  endfunction

  assign busy    = (state != S_IDLE);
  assign bs_col  = (cur_col != 7'd0) ? cur_col - 7'd1 : 7'd0;
  assign col_inc = {1'b0, cur_col} + 8'd1;
  assign rd_in   = (req.read_row <= ROW_LAST) && (req.read_col <= COL_LAST);
  assign raddr   = {phys(req.read_row[RW-1:0], top), req.read_col[CW-1:0]};

  always_comb begin
    we    = 1'b0;
    waddr = {phys(cur_row[RW-1:0], top), cur_col[CW-1:0]};
    wdata = '{ch: ch, fg: cur_fg, bg: cur_bg, attr: cur_attr};
    unique case (state)
      S_RCLR: begin
        we    = 1'b1;
        waddr = {clr_r, clr_c};
        wdata = '{ch: 8'd0, fg: tte_pkg::FG_RESET, bg: 4'd0, attr: 8'd0};
      end
      S_PUT: we = 1'b1;
      S_CLRR: begin
        we    = 1'b1;
        waddr = {clr_r, clr_c};
        wdata.ch = tte_pkg::CH_SPACE;
      end
      S_IDLE: begin
        if (start && req.req_type == tte_pkg::REQ_BYTE && phase == tte_pkg::ESC_NONE
            && req.data_byte == tte_pkg::CH_BS) begin
          we       = 1'b1;
          waddr    = {phys(cur_row[RW-1:0], top), bs_col[CW-1:0]};
          wdata.ch = tte_pkg::CH_SPACE;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RCLR;
      phase    <= tte_pkg::ESC_NONE;
      cur_row  <= 5'd0;
      cur_col  <= 7'd0;
      cur_fg   <= tte_pkg::FG_RESET;
      cur_bg   <= 4'd0;
      cur_attr <= 8'd0;
      top      <= '0;
      clr_r    <= '0;
      clr_c    <= '0;
      tab      <= 1'b0;
      more     <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      strobe <= 1'b0;
      res    <= '0;
      unique case (state)
        S_RCLR: begin
          if (clr_c == CW'(COLUMNS - 1)) begin
            clr_c <= '0;
            if (clr_r == RW'(ROWS - 1)) state <= S_IDLE;
            else clr_r <= clr_r + 1'b1;
          end else begin
            clr_c <= clr_c + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            unique case (req.req_type)
              tte_pkg::REQ_BYTE: begin
                if (phase == tte_pkg::ESC_SEEN) begin
                  phase <= (req.data_byte == tte_pkg::CH_LBRK) ? tte_pkg::ESC_CSI
                                                              : tte_pkg::ESC_NONE;
                end else if (phase == tte_pkg::ESC_CSI) begin
                  if (req.data_byte >= tte_pkg::CH_FINLO && req.data_byte <= tte_pkg::CH_FINHI)
                    phase <= tte_pkg::ESC_NONE;
                end else if (req.data_byte == tte_pkg::CH_ESC) begin
                  phase <= tte_pkg::ESC_SEEN;
                end else if (req.data_byte == tte_pkg::CH_CR) begin
                  cur_col      <= 7'd0;
                  strobe       <= 1'b1;
                  res.kind     <= tte_pkg::KIND_CURSOR;
                  res.out_row  <= cur_row;
                  res.last     <= 1'b1;
                end else if (req.data_byte == tte_pkg::CH_LF) begin
                  cur_col <= 7'd0;
                  more    <= 1'b0;
                  if (cur_row == ROW_LAST) begin
                    state <= S_SCRL;
                  end else begin
                    cur_row     <= cur_row + 5'd1;
                    strobe      <= 1'b1;
                    res.kind    <= tte_pkg::KIND_CURSOR;
                    res.out_row <= cur_row + 5'd1;
                    res.last    <= 1'b1;
                  end
                end else if (req.data_byte == tte_pkg::CH_BS) begin
                  cur_col      <= bs_col;
                  more         <= 1'b0;
                  strobe       <= 1'b1;
                  res.kind     <= tte_pkg::KIND_CELL;
                  res.out_row  <= cur_row;
                  res.out_col  <= bs_col;
                  res.out_char <= tte_pkg::CH_SPACE;
                  res.out_fg   <= cur_fg;
                  res.out_bg   <= cur_bg;
                  state        <= S_CUR;
                end else if (req.data_byte == tte_pkg::CH_TAB) begin
                  ch    <= tte_pkg::CH_SPACE;
                  tab   <= 1'b1;
                  stop  <= ({1'b0, cur_col} + 8'd8) & ~8'd7;
                  state <= S_PUT;
                end else begin
                  ch    <= req.data_byte;
                  tab   <= 1'b0;
                  state <= S_PUT;
                end
              end
              tte_pkg::REQ_COLOR: begin
                if (req.new_fg <= 8'd15) cur_fg <= req.new_fg[3:0];
                if (req.new_bg <= 8'd15) cur_bg <= req.new_bg[3:0];
                cur_attr <= req.new_attr;
              end
              tte_pkg::REQ_READ: begin
                rd_row <= req.read_row;
                rd_col <= req.read_col;
                if (rd_in) begin
                  state <= S_RD;
                end else begin
                  strobe      <= 1'b1;
                  res.kind    <= tte_pkg::KIND_READ;
                  res.out_row <= req.read_row;
                  res.out_col <= req.read_col;
                  res.last    <= 1'b1;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PUT: begin
          strobe       <= 1'b1;
          res.kind     <= tte_pkg::KIND_CELL;
          res.out_row  <= cur_row;
          res.out_col  <= cur_col;
          res.out_char <= ch;
          res.out_fg   <= cur_fg;
          res.out_bg   <= cur_bg;
          if (col_inc >= COL_END) begin
            cur_col <= 7'd0;
            more    <= 1'b0;
            if (cur_row == ROW_LAST) begin
              state <= S_SCRL;
            end else begin
              cur_row <= cur_row + 5'd1;
              state   <= S_CUR;
            end
          end else begin
            cur_col <= col_inc[6:0];
            more    <= tab && (col_inc < stop);
            state   <= S_CUR;
          end
        end
        S_SCRL: begin
          strobe   <= 1'b1;
          res.kind <= tte_pkg::KIND_SCROLL;
          // old top row becomes the new bottom row
          clr_r    <= top;
          clr_c    <= '0;
          top      <= (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;
          state    <= S_CLRR;
        end
        S_CLRR: begin
          if (clr_c == CW'(COLUMNS - 1)) state <= S_CUR;
          else clr_c <= clr_c + 1'b1;
        end
        S_CUR: begin
          strobe      <= 1'b1;
          res.kind    <= tte_pkg::KIND_CURSOR;
          res.out_row <= cur_row;
          res.out_col <= cur_col;
          res.last    <= !more;
          state       <= more ? S_PUT : S_IDLE;
        end
        S_RD: begin
          strobe       <= 1'b1;
          res.kind     <= tte_pkg::KIND_READ;
          res.out_row  <= rd_row;
          res.out_col  <= rd_col;
          res.out_char <= rd_q.ch;
          res.out_fg   <= rd_q.fg;
          res.out_bg   <= rd_q.bg;
          res.out_attr <= rd_q.attr;
          res.last     <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TTE_ASSERT_ALWAYS(a_row_range, cur_row <= ROW_LAST, "cursor row out of range")
  `TTE_ASSERT_ALWAYS(a_col_range, cur_col <= COL_LAST, "cursor column out of range")
  `TTE_ASSERT_IMPL(a_scroll_not_last, strobe && res.kind == tte_pkg::KIND_SCROLL, !res.last, "scroll marked last")
  `TTE_ASSERT_IMPL(a_top_range, 1'b1, top <= RW'(ROWS - 1), "top row pointer out of range")

endmodule

FILE: tb/tb_text_terminal_output_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_terminal_output_engine_unit
// Self-checking bench for the text terminal output engine. Request words
// (bytes, color changes, cell reads, unused types) go in through the start/busy handshake.
// A screen model built into the bench predicts every cell write, cursor
// update, scroll notice and read word. Each strobed word is checked against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_text_terminal_output_engine_unit;

  localparam int COLS     = tte_pkg::DEF_COLUMNS;
  localparam int LINES    = tte_pkg::DEF_ROWS;
  localparam int CELLS    = COLS * LINES;
  localparam int QUIET_MAX = 20000;   // clear pass plus many scrolls, with margin
  localparam int DRAIN    = 300;      // longest tab with a scroll fits in this
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  tte_pkg::in_t  req = '0;
  logic strobe;
  tte_pkg::out_t res;

  text_terminal_output_engine_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .strobe(strobe),
    .res   (res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Screen model
  // --------------------------------------------------------------------------
  tte_pkg::cell_t screen [CELLS];
  logic [1:0]     esc_phase;
  int             cur_row, cur_col;
  logic [3:0]     pen_fg, pen_bg;
  logic [7:0]     pen_attr;
  tte_pkg::out_t  expected_words [$];

  int  errors = 0;
  int  quiet_cycles = 0;
  bit  idle_on = 1'b1;

  function automatic void push_word(logic [1:0] k, int row, int col, logic [7:0] ch,
                                    logic [3:0] fg, logic [3:0] bg, logic [7:0] attr);
    tte_pkg::out_t w;
    w.kind = k; w.out_row = row[4:0]; w.out_col = col[6:0];
    w.out_char = ch; w.out_fg = fg; w.out_bg = bg; w.out_attr = attr; w.last = 1'b0;
    expected_words.push_back(w);
  endfunction

  function automatic void store_cell(logic [7:0] ch);
    int idx;
    idx = cur_row * COLS + cur_col;
    screen[idx] = '{ch: ch, fg: pen_fg, bg: pen_bg, attr: pen_attr};
    push_word(tte_pkg::KIND_CELL, cur_row, cur_col, ch, pen_fg, pen_bg, 8'h00);
  endfunction

  function automatic void line_down();
    if (cur_row + 1 >= LINES) begin
      // rows shift up; the fresh bottom row is spaces in the current pen
      for (int i = 0; i < (LINES - 1) * COLS; i++) screen[i] = screen[i + COLS];
      for (int c = 0; c < COLS; c++)
        screen[(LINES - 1) * COLS + c] = '{ch: tte_pkg::CH_SPACE, fg: pen_fg, bg: pen_bg,
                                            attr: pen_attr};
      push_word(tte_pkg::KIND_SCROLL, 0, 0, 8'h00, 4'h0, 4'h0, 8'h00);
      cur_row = LINES - 1;
    end else begin
      cur_row++;
    end
  endfunction

  function automatic bit put_glyph(logic [7:0] ch);
    bit wrapped;
    wrapped = 1'b0;
    store_cell(ch);
    cur_col++;
    if (cur_col >= COLS) begin
      cur_col = 0;
      line_down();
      wrapped = 1'b1;
    end
    push_word(tte_pkg::KIND_CURSOR, cur_row, cur_col, 8'h00, 4'h0, 4'h0, 8'h00);
    return wrapped;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    int stop;
    case (b)
      tte_pkg::CH_CR: begin
        cur_col = 0;
        push_word(tte_pkg::KIND_CURSOR, cur_row, cur_col, 8'h00, 4'h0, 4'h0, 8'h00);
      end
      tte_pkg::CH_LF: begin
        cur_col = 0;
        line_down();
        push_word(tte_pkg::KIND_CURSOR, cur_row, cur_col, 8'h00, 4'h0, 4'h0, 8'h00);
      end
      tte_pkg::CH_BS: begin
        if (cur_col > 0) cur_col--;
        store_cell(tte_pkg::CH_SPACE);
        push_word(tte_pkg::KIND_CURSOR, cur_row, cur_col, 8'h00, 4'h0, 4'h0, 8'h00);
      end
      tte_pkg::CH_TAB: begin
        // stops at the next multiple of eight, or right after a wrap
        stop = (cur_col + 8) & ~7;
        while (cur_col < stop) begin
          if (put_glyph(tte_pkg::CH_SPACE)) break;
        end
      end
      default: void'(put_glyph(b));
    endcase
  endfunction

  function automatic void predict_word(tte_pkg::in_t w);
    int            n0, idx;
    tte_pkg::out_t t;
    n0 = expected_words.size();
    case (w.req_type)
      tte_pkg::REQ_BYTE: begin
        if (esc_phase == tte_pkg::ESC_SEEN)
          esc_phase = (w.data_byte == tte_pkg::CH_LBRK) ? tte_pkg::ESC_CSI
                                                        : tte_pkg::ESC_NONE;
        else if (esc_phase == tte_pkg::ESC_CSI) begin
          if (w.data_byte >= tte_pkg::CH_FINLO && w.data_byte <= tte_pkg::CH_FINHI)
            esc_phase = tte_pkg::ESC_NONE;
        end else if (w.data_byte == tte_pkg::CH_ESC)
          esc_phase = tte_pkg::ESC_SEEN;
        else
          put_byte(w.data_byte);
      end
      tte_pkg::REQ_COLOR: begin
        if (w.new_fg <= 8'd15) pen_fg = w.new_fg[3:0];
        if (w.new_bg <= 8'd15) pen_bg = w.new_bg[3:0];
        pen_attr = w.new_attr;
      end
      tte_pkg::REQ_READ: begin
        if (w.read_row < LINES && w.read_col < COLS) begin
          idx = w.read_row * COLS + w.read_col;
          push_word(tte_pkg::KIND_READ, w.read_row, w.read_col, screen[idx].ch,
                    screen[idx].fg, screen[idx].bg, screen[idx].attr);
        end else begin
          push_word(tte_pkg::KIND_READ, w.read_row, w.read_col, 8'h00, 4'h0, 4'h0, 8'h00);
        end
      end
      default: ;
    endcase
    if (expected_words.size() > n0) begin
      t = expected_words.pop_back();
      t.last = 1'b1;
      expected_words.push_back(t);
    end
  endfunction

  initial begin
    esc_phase = tte_pkg::ESC_NONE;
    cur_row = 0; cur_col = 0;
    pen_fg = tte_pkg::FG_RESET; pen_bg = 4'h0; pen_attr = 8'h00;
    for (int i = 0; i < CELLS; i++) screen[i] = '{ch: 8'h00, fg: tte_pkg::FG_RESET,
                                                  bg: 4'h0, attr: 8'h00};
  end

  // --------------------------------------------------------------------------
  // Monitor: acceptance feeds the model, strobed words are checked.
  // Sampled at the rising edge, before the block's own updates land.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    tte_pkg::out_t e;
    bit            moved;
    moved = 1'b0;
    if (!rst && strobe) begin
      moved = 1'b1;
      if (expected_words.size() == 0) begin
        $error("unexpected result word kind=%0d", res.kind);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (res.kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, res.kind); errors++;
        end
        if (res.out_row !== e.out_row) begin
          $error("out_row: expected %0d, got %0d", e.out_row, res.out_row); errors++;
        end
        if (res.out_col !== e.out_col) begin
          $error("out_col: expected %0d, got %0d", e.out_col, res.out_col); errors++;
        end
        if (res.out_char !== e.out_char) begin
          $error("out_char: expected %0h, got %0h", e.out_char, res.out_char); errors++;
        end
        if (res.out_fg !== e.out_fg) begin
          $error("out_fg: expected %0d, got %0d", e.out_fg, res.out_fg); errors++;
        end
        if (res.out_bg !== e.out_bg) begin
          $error("out_bg: expected %0d, got %0d", e.out_bg, res.out_bg); errors++;
        end
        if (res.out_attr !== e.out_attr) begin
          $error("out_attr: expected %0h, got %0h", e.out_attr, res.out_attr); errors++;
        end
        if (res.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, res.last); errors++;
        end
      end
    end
    if (!rst && start && !busy) begin
      moved = 1'b1;
      predict_word(req);
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // watchdog on cycles where nothing moves in either direction
  always @(posedge clk) begin
    if (quiet_cycles >= QUIET_MAX) begin
      $display("text_terminal_output_engine_unit test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driver: called at a falling edge, returns at the falling edge after the
  // word was taken.
  // --------------------------------------------------------------------------
  function automatic tte_pkg::in_t noise_word();
    return tte_pkg::in_t'($bits(tte_pkg::in_t)'({$urandom, $urandom}));
  endfunction

  task automatic send_word(tte_pkg::in_t w);
    while (idle_on && $urandom_range(99) < 21) begin
      start <= 1'b0;
      req   <= noise_word();
      @(negedge clk);
    end
    start <= 1'b1;
    req   <= w;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b);
    tte_pkg::in_t w;
    w = noise_word();
    w.req_type = tte_pkg::REQ_BYTE; w.data_byte = b;
    send_word(w);
  endtask

  task automatic send_color(logic [7:0] fg, logic [7:0] bg, logic [7:0] attr);
    tte_pkg::in_t w;
    w = noise_word();
    w.req_type = tte_pkg::REQ_COLOR; w.new_fg = fg; w.new_bg = bg; w.new_attr = attr;
    send_word(w);
  endtask

  task automatic send_read(logic [4:0] row, logic [6:0] col);
    tte_pkg::in_t w;
    w = noise_word();
    w.req_type = tte_pkg::REQ_READ; w.read_row = row; w.read_col = col;
    send_word(w);
  endtask

  task automatic send_unused();
    tte_pkg::in_t w;
    w = noise_word();
    w.req_type = REQ_UNUSED;
    send_word(w);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_reset_cells();
    send_read(5'd0, 7'd0);
    send_read(5'd24, 7'd79);
    send_read(5'd31, 7'd127);          // off screen echoes the position
  endtask

  task automatic test_glyphs_and_controls();
    send_color(8'd3, 8'd12, 8'hA5);
    send_byte(8'h00);                  // NUL is a printable cell
    send_byte(8'hFF);
    send_color(8'd200, 8'd255, 8'h5A); // colors out of range are kept as they were
    send_byte(8'h07);                  // other control bytes print too
    send_byte(tte_pkg::CH_BS);
    send_byte(tte_pkg::CH_CR);
    send_byte(tte_pkg::CH_BS);         // backspace at column 0 erases in place
    send_byte(tte_pkg::CH_LF);
    send_read(5'd0, 7'd0);
    send_unused();
  endtask

  task automatic test_escapes();
    send_byte(tte_pkg::CH_ESC); send_byte(tte_pkg::CH_LBRK);
    send_byte(8'h31); send_byte(tte_pkg::CH_FINHI);
    send_byte(tte_pkg::CH_ESC); send_byte(8'h41);
  endtask

  task automatic test_tab_wrap();
    send_byte(tte_pkg::CH_CR);
    // nine tabs reach column 72, the tenth wraps and stops there
    for (int i = 0; i < 10; i++) send_byte(tte_pkg::CH_TAB);
  endtask

  task automatic send_random_byte();
    int p;
    p = $urandom_range(99);
    if (p < 55)      send_byte(8'($urandom_range(8'h20, 8'h7E)));
    else if (p < 63) send_byte(tte_pkg::CH_LF);
    else if (p < 67) send_byte(tte_pkg::CH_CR);
    else if (p < 72) send_byte(tte_pkg::CH_BS);
    else if (p < 79) send_byte(tte_pkg::CH_TAB);
    else             send_byte(8'($urandom));
  endtask

  task automatic test_random(int count);
    int  p, n;
    for (int i = 0; i < count; i++) begin
      idle_on = !(i >= 150 && i < 260);     // long stretch with back-to-back words
      p = $urandom_range(99);
      if (p < 55) send_random_byte();
      else if (p < 65) begin
        // well-formed CSI with a random parameter run
        send_byte(tte_pkg::CH_ESC); send_byte(tte_pkg::CH_LBRK);
        n = $urandom_range(3);
        for (int k = 0; k < n; k++) send_byte(8'($urandom_range(8'h20, 8'h3F)));
        send_byte(8'($urandom_range(tte_pkg::CH_FINLO, tte_pkg::CH_FINHI)));
      end else if (p < 68) begin
        send_byte(tte_pkg::CH_ESC); send_byte(8'($urandom));
      end else if (p < 76) begin
        send_color($urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom),
                   $urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom),
                   8'($urandom));
      end else if (p < 97) begin
        if ($urandom_range(9) == 0) send_read(5'($urandom), 7'($urandom));
        else send_read(5'($urandom_range(LINES - 1)), 7'($urandom_range(COLS - 1)));
      end else begin
        send_unused();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_cells();
    test_glyphs_and_controls();
    test_escapes();
    test_tab_wrap();
    test_random(320);
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0)
      $display("text_terminal_output_engine_unit test passed");
    else
      $display("text_terminal_output_engine_unit test failed");
    $finish;
  end

endmodule

FILE: text_terminal_output_engine_unit.f
+incdir+src
src/tte_pkg.sv
src/text_terminal_output_engine_unit.sv
tb/tb_text_terminal_output_engine_unit.sv
